// ===== hw/rtl/czs_pkg.sv =====
// Shared types, codes and helpers for the column z-score standardizer.
`timescale 1ns / 1ps

package czs_pkg;

    // Field and storage widths.
    localparam int COL_W      = 4;
    localparam int NUM_COLS   = 16;
    localparam int SAMPLE_W   = 16;
    localparam int SPREAD_W   = 15;
    localparam int STATUS_W   = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 5;
    localparam int SUM_W      = 33;
    localparam int SQ_W       = 47;
    localparam int CNT_W      = 17;
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 18;
    localparam int DIV_CNT_W  = 6;
    localparam int SQRT_IN_W  = 32;
    localparam int SQRT_CNT_W = 5;

    // Input kinds.
    localparam logic [KIND_W-1:0] KIND_ACC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STD    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNDO   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FITTED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SAMPLES = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_STD   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_COLUMN = 3'd4;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_LOAD,
        ST_STD_CHK,
        ST_STD_WAIT,
        ST_UNDO_MUL,
        ST_UNDO_FIX,
        ST_FIN_READ,
        ST_FIN_CHK,
        ST_MEAN_WAIT,
        ST_MSQ,
        ST_EX2_WAIT,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_EMIT
    } state_t;

    // Saturate a signed value to the 16-bit sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [48:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 49'sd32767)
        begin
            r = 16'sd32767;
        end
        else if (v < -49'sd32768)
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/czs_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module czs_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [czs_pkg::DIV_NUM_W-1:0]  num,
    input  logic [czs_pkg::DIV_DEN_W-1:0]  den,
    output logic [czs_pkg::DIV_NUM_W-1:0]  quot,
    output czs_pkg::unit_status_t          status
);
    import czs_pkg::*;

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    // One shift and trial subtraction per cycle.
    always_comb
    begin
        trial = {rem_reg, num_reg[DIV_NUM_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], qbit};
            rem_reg <= qbit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        end
    end

    assign quot        = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/czs_sqrt.sv =====
// Integer square root that settles two radicand bits per cycle.
`timescale 1ns / 1ps

module czs_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [czs_pkg::SQRT_IN_W-1:0]  radicand,
    output logic [15:0]                    root,
    output logic [16:0]                    remainder,
    output czs_pkg::unit_status_t          status
);
    import czs_pkg::*;

    logic [SQRT_IN_W-1:0]  v_reg;
    logic [SQRT_IN_W-1:0]  r_reg;
    logic [SQRT_IN_W-1:0]  bit_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_IN_W-1:0]  trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(SQRT_IN_W / 2);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Digit-by-digit root: subtract the trial square where it fits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root        = r_reg[15:0];
    assign remainder   = v_reg[16:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/column_zscore_standardizer.sv =====
// Per-column z-score standardizer: accumulators, fit sequencer and transforms.
// Standardize uses one divider pass; undo uses the multiplier only; errors skip both.
// A finish word runs two divider passes and a square root per active column with
// samples and skips them for an empty column; output stalls hold the sequencer.
// One word at a time: the next word is taken only back in the idle state.
// Reset (asynchronous, active low) clears accumulators, fit flag and output.
`timescale 1ns / 1ps

module column_zscore_standardizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // active_columns
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // column[3:0], sample[19:4], zero pad
    input  logic [1:0]  s_tuser,       // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // result_value[15:0], result_spread[30:16],
                                       // result_column[34:31], zero pad
    output logic [2:0]  m_tuser,       // status[2:0]
    output logic        m_tlast
);
    import czs_pkg::*;

    state_t state_reg, state_next;

    // Configuration and accumulator state.
    logic [CFG_W-1:0]          cfg_reg;
    logic [CFG_W-1:0]          n_eff;
    logic signed [SUM_W-1:0]   sum_mem [NUM_COLS];
    logic [SQ_W-1:0]           sq_mem  [NUM_COLS];
    logic [CNT_W-1:0]          cnt_mem [NUM_COLS];
    logic signed [SAMPLE_W-1:0] mean_mem [NUM_COLS];
    logic [SPREAD_W-1:0]       std_mem  [NUM_COLS];
    logic                      stats_valid_reg;

    // Work registers.
    logic [KIND_W-1:0]          kind_reg;
    logic [COL_W-1:0]           col_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [SPREAD_W-1:0]        std_reg;
    logic signed [31:0]         prod_reg;
    logic signed [SUM_W-1:0]    sum_rd_reg;
    logic [SQ_W-1:0]            sq_rd_reg;
    logic [CNT_W-1:0]           cnt_rd_reg;
    logic [SQRT_IN_W-1:0]       var_reg;

    // Pending result and output register.
    logic signed [SAMPLE_W-1:0] res_value_reg;
    logic [SPREAD_W-1:0]        res_spread_reg;
    logic [STATUS_W-1:0]        res_status_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic [SPREAD_W-1:0]        out_spread_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic                       out_last_reg;

    // Input word fields.
    logic [KIND_W-1:0]          in_kind;
    logic [COL_W-1:0]           in_col;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_accept;

    // Control strobes and helpers.
    logic                       div_start;
    logic                       sqrt_start;
    logic                       emit_load;
    logic                       out_free;
    logic                       last_col;
    logic                       fin_clear;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DIV_DEN_W-1:0]       div_den;
    logic [DIV_NUM_W-1:0]       div_quot;
    unit_status_t               div_stat;
    logic [15:0]                sqrt_root;
    logic [16:0]                sqrt_rem;
    unit_status_t               sqrt_stat;
    logic [SUM_W-1:0]           sum_mag;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          diff_mag;
    logic [30:0]                prod_mag;
    logic [23:0]                undo_q;
    logic signed [48:0]         undo_sum;
    logic signed [48:0]         quot_signed;
    logic [16:0]                root_rnd;
    logic [SQ_W-1:0]            msq_wide;

    assign in_kind   = s_tuser;
    assign in_col    = s_tdata[3:0];
    assign in_sample = s_tdata[19:4];
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Effective column count: zero acts as one, capped at the column total.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (cfg_reg > CFG_W'(NUM_COLS))
        begin
            n_eff = CFG_W'(NUM_COLS);
        end
        else
        begin
            n_eff = cfg_reg;
        end
    end

    assign last_col  = ({1'b0, col_reg} == (n_eff - 1'b1));
    assign fin_clear = emit_load && (kind_reg == KIND_FINISH) && last_col;

    // Arithmetic helpers around the shared units.
    always_comb
    begin
        sum_mag     = sum_rd_reg[SUM_W-1] ? SUM_W'(-sum_rd_reg) : SUM_W'(sum_rd_reg);
        diff        = $signed({x_reg[SAMPLE_W-1], x_reg}) -
                      $signed({mean_reg[SAMPLE_W-1], mean_reg});
        diff_mag    = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
        prod_mag    = prod_reg[31] ? 31'(-prod_reg) : prod_reg[30:0];
        undo_q      = 24'((32'(prod_mag) + 32'd128) >> 8);
        undo_sum    = (prod_reg[31] ? -$signed({25'd0, undo_q}) : $signed({25'd0, undo_q}))
                      + 49'(mean_reg);
        quot_signed = $signed({1'b0, div_quot});
        root_rnd    = {1'b0, sqrt_root} + ((sqrt_rem > {1'b0, sqrt_root}) ? 17'd1 : 17'd0);
        msq_wide    = SQ_W'(prod_reg[30:0]);
    end

    // Divider operand selection.
    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_FIN_CHK:
            begin
                div_num = DIV_NUM_W'({sum_mag, 1'b0}) + DIV_NUM_W'(cnt_rd_reg);
                div_den = {cnt_rd_reg, 1'b0};
            end
            ST_MSQ:
            begin
                div_num = DIV_NUM_W'(sq_rd_reg);
                div_den = DIV_DEN_W'(cnt_rd_reg);
            end
            ST_STD_CHK:
            begin
                div_num = DIV_NUM_W'({diff_mag, 9'd0}) + DIV_NUM_W'(std_reg);
                div_den = DIV_DEN_W'({std_reg, 1'b0});
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_kind == KIND_FINISH)
                    begin
                        state_next = ST_FIN_READ;
                    end
                    else if ({1'b0, in_col} >= n_eff)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (in_kind == KIND_ACC)
                    begin
                        state_next = ST_ACC_MUL;
                    end
                    else if (!stats_valid_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_ACC_MUL:   state_next = ST_ACC_ADD;
            ST_ACC_ADD:   state_next = ST_IDLE;
            ST_LOAD:      state_next = (kind_reg == KIND_STD) ? ST_STD_CHK : ST_UNDO_MUL;
            ST_STD_CHK:   state_next = (std_reg == '0) ? ST_EMIT : ST_STD_WAIT;
            ST_STD_WAIT:  state_next = div_stat.done ? ST_EMIT : ST_STD_WAIT;
            ST_UNDO_MUL:  state_next = ST_UNDO_FIX;
            ST_UNDO_FIX:  state_next = ST_EMIT;
            ST_FIN_READ:  state_next = ST_FIN_CHK;
            ST_FIN_CHK:   state_next = (cnt_rd_reg == '0) ? ST_EMIT : ST_MEAN_WAIT;
            ST_MEAN_WAIT: state_next = div_stat.done ? ST_MSQ : ST_MEAN_WAIT;
            ST_MSQ:       state_next = ST_EX2_WAIT;
            ST_EX2_WAIT:  state_next = div_stat.done ? ST_SQRT : ST_EX2_WAIT;
            ST_SQRT:      state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: state_next = sqrt_stat.done ? ST_EMIT : ST_SQRT_WAIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if ((kind_reg == KIND_FINISH) && !last_col)
                    begin
                        state_next = ST_FIN_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            ST_IDLE:    s_tready  = 1'b1;
            ST_STD_CHK: div_start = (std_reg != '0);
            ST_FIN_CHK: div_start = (cnt_rd_reg != '0);
            ST_MSQ:     div_start = 1'b1;
            ST_SQRT:    sqrt_start = 1'b1;
            ST_EMIT:    emit_load = out_free;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration register and fit flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= CFG_W'(NUM_COLS);
            stats_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (fin_clear)
            begin
                stats_valid_reg <= 1'b1;
            end
        end
    end

    // Accumulators: one column per accumulate word until its count reaches 2**16, all cleared by a finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COLS; i++)
            begin
                sum_mem[i] <= '0;
                sq_mem[i]  <= '0;
                cnt_mem[i] <= '0;
            end
        end
        else if (fin_clear)
        begin
            for (int i = 0; i < NUM_COLS; i++)
            begin
                sum_mem[i] <= '0;
                sq_mem[i]  <= '0;
                cnt_mem[i] <= '0;
            end
        end
        else if ((state_reg == ST_ACC_ADD) && !cnt_mem[col_reg][CNT_W-1])
        begin
            sum_mem[col_reg] <= sum_mem[col_reg] + SUM_W'(x_reg);
            sq_mem[col_reg]  <= sq_mem[col_reg] + SQ_W'(prod_reg[30:0]);
            cnt_mem[col_reg] <= cnt_mem[col_reg] + 1'b1;
        end
    end

    // Fitted statistics, written once per active column by each finish.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN_CHK) && (cnt_rd_reg == '0))
        begin
            mean_mem[col_reg] <= '0;
            std_mem[col_reg]  <= '0;
        end
        else if ((state_reg == ST_SQRT_WAIT) && sqrt_stat.done)
        begin
            mean_mem[col_reg] <= mean_reg;
            std_mem[col_reg]  <= root_rnd[16:15] != 2'd0 ? 15'h7FFF : root_rnd[14:0];
        end
    end

    // Work datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    kind_reg       <= in_kind;
                    x_reg          <= in_sample;
                    col_reg        <= (in_kind == KIND_FINISH) ? '0 : in_col;
                    res_value_reg  <= '0;
                    res_spread_reg <= '0;
                    res_status_reg <= ({1'b0, in_col} >= n_eff) ? STAT_BAD_COLUMN
                                                               : STAT_NOT_FITTED;
                end
            end
            ST_ACC_MUL:
            begin
                prod_reg <= x_reg * x_reg;
            end
            ST_LOAD:
            begin
                mean_reg <= mean_mem[col_reg];
                std_reg  <= std_mem[col_reg];
            end
            ST_STD_CHK:
            begin
                res_status_reg <= (std_reg == '0) ? STAT_ZERO_STD : STAT_OK;
                if (diff > 0)
                begin
                    res_value_reg <= 16'sd32767;
                end
                else if (diff < 0)
                begin
                    res_value_reg <= -16'sd32768;
                end
                else
                begin
                    res_value_reg <= '0;
                end
            end
            ST_STD_WAIT:
            begin
                if (div_stat.done)
                begin
                    res_value_reg <= sat16(diff[SAMPLE_W] ? -quot_signed : quot_signed);
                end
            end
            ST_UNDO_MUL:
            begin
                prod_reg <= x_reg * $signed({1'b0, std_reg});
            end
            ST_UNDO_FIX:
            begin
                res_value_reg  <= sat16(undo_sum);
                res_status_reg <= STAT_OK;
            end
            ST_FIN_READ:
            begin
                sum_rd_reg <= sum_mem[col_reg];
                sq_rd_reg  <= sq_mem[col_reg];
                cnt_rd_reg <= cnt_mem[col_reg];
            end
            ST_FIN_CHK:
            begin
                res_value_reg  <= '0;
                res_spread_reg <= '0;
                res_status_reg <= (cnt_rd_reg == '0) ? STAT_NO_SAMPLES : STAT_OK;
            end
            ST_MEAN_WAIT:
            begin
                if (div_stat.done)
                begin
                    mean_reg <= sat16(sum_rd_reg[SUM_W-1] ? -quot_signed : quot_signed);
                end
            end
            ST_MSQ:
            begin
                prod_reg <= mean_reg * mean_reg;
            end
            ST_EX2_WAIT:
            begin
                if (div_stat.done)
                begin
                    var_reg <= (div_quot[SQ_W-1:0] > msq_wide)
                               ? SQRT_IN_W'(div_quot[SQ_W-1:0] - msq_wide) : '0;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    res_value_reg  <= mean_reg;
                    res_spread_reg <= root_rnd[16:15] != 2'd0 ? 15'h7FFF : root_rnd[14:0];
                end
            end
            ST_EMIT:
            begin
                if (emit_load && (kind_reg == KIND_FINISH) && !last_col)
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // Output register: holds one word while the sequencer goes on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_value_reg  <= res_value_reg;
            out_spread_reg <= res_spread_reg;
            out_col_reg    <= col_reg;
            out_status_reg <= res_status_reg;
            out_last_reg   <= (kind_reg != KIND_FINISH) || last_col;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_col_reg, out_spread_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Shared arithmetic units.
    czs_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .status (div_stat)
    );

    czs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sqrt_start),
        .radicand  (var_reg),
        .root      (sqrt_root),
        .remainder (sqrt_rem),
        .status    (sqrt_stat)
    );

endmodule

// ===== hw/rtl/czs_checker.sv =====
// Port-level checks for the column z-score standardizer and their binding.
`timescale 1ns / 1ps

module czs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import czs_pkg::*;

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // No result word is shown while reset is held.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // Results with an error status carry no spread.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[30:16] == 15'd0))
        else $error("spread set on an error result");

    // Error results for a bad column or a missing fit end their run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == STAT_BAD_COLUMN) || (m_tuser == STAT_NOT_FITTED))
        |-> m_tlast)
        else $error("single error result not marked last");

endmodule

bind column_zscore_standardizer czs_checker u_czs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
